### rtl/sltm_pkg.sv
// Shared types, codes and constants of the scrolling text LED matrix scan driver.
package sltm_pkg;

    localparam int MAX_MODULES_DEF = 8;
    localparam int TEXT_DEPTH_DEF  = 64;
    localparam int GLYPH_COUNT_DEF = 96;

    localparam int CHAR_PITCH      = 6;
    localparam int GLYPH_WIDTH     = 5;
    localparam int FIRST_CODE      = 32;
    localparam int COLS_PER_MODULE = 8;
    localparam int GLYPH_W         = 7;
    localparam int CFG_W           = 16;
    localparam int DIVIDEND_W      = 9;
    localparam int DIVISOR_W       = 7;
    localparam int PITCH_RECIP     = 171;
    localparam int PITCH_SHIFT     = 10;

    localparam logic [1:0] KIND_TICK = 2'd0;
    localparam logic [1:0] KIND_TEXT = 2'd1;
    localparam logic [1:0] KIND_FONT = 2'd2;

    localparam logic [1:0] CFG_MODULE_COUNT    = 2'd0;
    localparam logic [1:0] CFG_DISPLAY_COLUMNS = 2'd1;
    localparam logic [1:0] CFG_STEP_FRAMES     = 2'd2;
    localparam logic [1:0] CFG_TEXT_LENGTH     = 2'd3;

    localparam logic [3:0]  MODULE_COUNT_RST    = 4'd1;
    localparam logic [6:0]  DISPLAY_COLUMNS_RST = 7'd8;
    localparam logic [15:0] STEP_FRAMES_RST     = 16'd125;
    localparam logic [6:0]  TEXT_LENGTH_RST     = 7'd0;

    typedef struct packed {
        logic [1:0] kind;
        logic [8:0] address;
        logic [7:0] value;
    } item_t;

    typedef struct packed {
        logic [2:0] select_column;
        logic [7:0] shift_byte;
        logic       latch_after;
        logic       last;
    } word_t;

    typedef struct packed {
        logic                  start;
        logic [DIVIDEND_W-1:0] dividend;
        logic [DIVISOR_W-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic                  done;
        logic [DIVISOR_W-1:0]  remainder;
    } div_rsp_t;

endpackage

### rtl/sltm_ram.sv
// Generic single-write, single-read RAM with registered read data.
module sltm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/sltm_div.sv
// Restoring divider, one quotient bit per cycle, gives the character index for the render set-up.
module sltm_div
    import sltm_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    localparam logic [3:0] LAST_STEP = 4'(DIVIDEND_W - 1);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [3:0]            step_reg, step_next;
    logic [DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [DIVISOR_W-1:0]  rem_reg, rem_next;
    logic [DIVISOR_W-1:0]  dvs_reg, dvs_next;
    logic [DIVISOR_W:0]    trial;
    logic [DIVISOR_W:0]    diff;

    always_comb
    begin
        trial     = {rem_reg, quo_reg[DIVIDEND_W-1]};
        diff      = trial - {1'b0, dvs_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            quo_next  = req.dividend;
            rem_next  = '0;
            dvs_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next = diff[DIVISOR_W-1:0];
                quo_next = {quo_reg[DIVIDEND_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[DIVISOR_W-1:0];
                quo_next = {quo_reg[DIVIDEND_W-2:0], 1'b0};
            end
            step_next = step_reg + 4'd1;
            if (step_reg == LAST_STEP)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done      = done_reg;
    assign rsp.remainder = rem_reg;

endmodule

### rtl/scrolling_text_led_matrix_scan.sv
// Top level of the scrolling text LED matrix scan driver: sequencer, stores and output word.
// Items are taken only while idle. A tick with M modules sends M blanking words, then M
// column words, each read from the column store first; the output may stall any word.
// A tick that ends a scan frame also re-renders: for non-empty text, a reciprocal split
// of the scroll position and a divider pass, then a column store write per display column,
// with a text read and font base step at each character boundary; empty text writes zeros.
// Reset is asynchronous: control registers take their reset values at once and the column store
// valid bits clear at once, so it reads as zero with no clearing pass.
module scrolling_text_led_matrix_scan
    import sltm_pkg::*;
#(
    parameter int MAX_MODULES = MAX_MODULES_DEF,
    parameter int TEXT_DEPTH  = TEXT_DEPTH_DEF,
    parameter int GLYPH_COUNT = GLYPH_COUNT_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_stall,
    input  item_t            item,
    output logic             result_valid,
    input  logic             result_stall,
    output word_t            result,
    input  logic             write_enable,
    input  logic [1:0]       write_index,
    input  logic [CFG_W-1:0] write_data
);

    localparam int COLUMN_DEPTH = COLS_PER_MODULE * MAX_MODULES;
    localparam int CA_W         = $clog2(COLUMN_DEPTH);
    localparam int FONT_DEPTH   = GLYPH_WIDTH * GLYPH_COUNT;
    localparam int FA_W         = (FONT_DEPTH > 1) ? $clog2(FONT_DEPTH) : 1;
    localparam int TA_W         = (TEXT_DEPTH > 1) ? $clog2(TEXT_DEPTH) : 1;

    localparam logic [3:0] ST_IDLE      = 4'd0;
    localparam logic [3:0] ST_BLANK     = 4'd1;
    localparam logic [3:0] ST_RDWAIT    = 4'd2;
    localparam logic [3:0] ST_DATA      = 4'd3;
    localparam logic [3:0] ST_ADV       = 4'd4;
    localparam logic [3:0] ST_SPLIT     = 4'd5;
    localparam logic [3:0] ST_DIV2_GO   = 4'd7;
    localparam logic [3:0] ST_DIV2_WAIT = 4'd8;
    localparam logic [3:0] ST_TXT       = 4'd9;
    localparam logic [3:0] ST_BASE      = 4'd10;
    localparam logic [3:0] ST_COL       = 4'd11;

    localparam logic [2:0] LAST_COLUMN = 3'd7;

    logic [3:0]              state_reg, state_next;
    logic [3:0]              module_count_reg, module_count_next;
    logic [6:0]              display_columns_reg, display_columns_next;
    logic [15:0]             step_frames_reg, step_frames_next;
    logic [6:0]              text_length_reg, text_length_next;
    logic [2:0]              scan_column_reg, scan_column_next;
    logic [15:0]             frame_counter_reg, frame_counter_next;
    logic [8:0]              scroll_position_reg, scroll_position_next;
    logic [COLUMN_DEPTH-1:0] col_valid_reg, col_valid_next;
    logic                    pend_reg, pend_next;
    logic                    result_valid_reg, result_valid_next;
    logic [3:0]              cnt_reg, cnt_next;
    logic [3:0]              mods_reg, mods_next;
    logic [6:0]              d_reg, d_next;
    logic [2:0]              col_reg, col_next;
    logic [6:0]              ch_reg, ch_next;
    logic                    zero_mode_reg, zero_mode_next;
    logic [8:0]              q_reg, q_next;
    logic [9:0]              base_reg, base_next;
    logic [6:0]              pend_addr_reg, pend_addr_next;
    logic                    pend_zero_reg, pend_zero_next;
    word_t                   result_reg, result_next;
    logic                    colv_rd_reg;

    logic              accept;
    logic              out_free;
    logic [3:0]        mods_clamped;
    logic [6:0]        len;
    logic [6:0]        cols;
    logic [9:0]        span;
    logic [15:0]       fc_inc;
    logic [8:0]        sp_inc;
    logic              sp_wrap;
    logic [16:0]       pitch_prod;
    logic [2:0]        pitch_rem;
    logic [6:0]        col_idx;
    logic [9:0]        faddr;
    logic              use_font;
    logic [6:0]        ch_inc;
    logic [GLYPH_W-1:0] glyph_code;

    logic [TA_W-1:0]    text_waddr;
    logic [TA_W-1:0]    text_raddr;
    logic               text_we;
    logic [GLYPH_W-1:0] text_rdata;
    logic [FA_W-1:0]    font_waddr;
    logic [FA_W-1:0]    font_raddr;
    logic               font_we;
    logic [7:0]         font_rdata;
    logic [CA_W-1:0]    col_waddr;
    logic [CA_W-1:0]    col_raddr;
    logic [7:0]         col_wdata;
    logic [7:0]         col_rdata;

    div_req_t div_req;
    div_rsp_t div_rsp;

    assign accept   = item_valid && (state_reg == ST_IDLE);
    assign out_free = !result_valid_reg || !result_stall;

    assign mods_clamped = (module_count_reg == 4'd0) ? 4'd1 :
                          (module_count_reg > 4'(MAX_MODULES)) ? 4'(MAX_MODULES) :
                          module_count_reg;
    assign len  = (32'(text_length_reg) > TEXT_DEPTH) ? 7'(TEXT_DEPTH) : text_length_reg;
    assign cols = (32'(display_columns_reg) > COLUMN_DEPTH) ? 7'(COLUMN_DEPTH) :
                  display_columns_reg;
    assign span = 10'({len, 2'b00}) + 10'({len, 1'b0});

    assign fc_inc  = frame_counter_reg + 16'd1;
    assign sp_inc  = scroll_position_reg + 9'd1;
    assign sp_wrap = (span < 10'(display_columns_reg)) || (10'(sp_inc) >= span);

    assign pitch_prod = 17'(scroll_position_reg) * 17'(PITCH_RECIP);
    assign pitch_rem  = 3'(scroll_position_reg - q_reg * 9'(CHAR_PITCH));

    assign col_idx  = {cnt_reg - 4'd1, scan_column_reg};
    assign faddr    = base_reg + 10'(col_reg);
    assign use_font = !zero_mode_reg && (32'(col_reg) < GLYPH_WIDTH) &&
                      (32'(faddr) < FONT_DEPTH);
    assign ch_inc   = ch_reg + 7'd1;

    assign glyph_code = ((32'(item.value) >= FIRST_CODE) &&
                         (32'(item.value) < FIRST_CODE + GLYPH_COUNT)) ?
                        GLYPH_W'(item.value - 8'(FIRST_CODE)) : '0;

    assign text_we    = accept && (item.kind == KIND_TEXT) && (32'(item.address) < TEXT_DEPTH);
    assign text_waddr = TA_W'(item.address);
    assign text_raddr = TA_W'(ch_reg);
    assign font_we    = accept && (item.kind == KIND_FONT) && (32'(item.address) < FONT_DEPTH);
    assign font_waddr = FA_W'(item.address);
    assign font_raddr = FA_W'(faddr);
    assign col_waddr  = pend_addr_reg[CA_W-1:0];
    assign col_wdata  = pend_zero_reg ? 8'd0 : font_rdata;
    assign col_raddr  = col_idx[CA_W-1:0];

    assign div_req.start    = (state_reg == ST_DIV2_GO);
    assign div_req.dividend = q_reg;
    assign div_req.divisor  = len;

    sltm_ram #(
        .WIDTH (GLYPH_W),
        .DEPTH (TEXT_DEPTH),
        .AW    (TA_W)
    ) u_text_ram (
        .clk   (clk),
        .we    (text_we),
        .waddr (text_waddr),
        .wdata (glyph_code),
        .raddr (text_raddr),
        .rdata (text_rdata)
    );

    sltm_ram #(
        .WIDTH (8),
        .DEPTH (FONT_DEPTH),
        .AW    (FA_W)
    ) u_font_ram (
        .clk   (clk),
        .we    (font_we),
        .waddr (font_waddr),
        .wdata (item.value),
        .raddr (font_raddr),
        .rdata (font_rdata)
    );

    sltm_ram #(
        .WIDTH (8),
        .DEPTH (COLUMN_DEPTH),
        .AW    (CA_W)
    ) u_col_ram (
        .clk   (clk),
        .we    (pend_reg),
        .waddr (col_waddr),
        .wdata (col_wdata),
        .raddr (col_raddr),
        .rdata (col_rdata)
    );

    sltm_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    always_comb
    begin
        state_next           = state_reg;
        module_count_next    = module_count_reg;
        display_columns_next = display_columns_reg;
        step_frames_next     = step_frames_reg;
        text_length_next     = text_length_reg;
        scan_column_next     = scan_column_reg;
        frame_counter_next   = frame_counter_reg;
        scroll_position_next = scroll_position_reg;
        col_valid_next       = col_valid_reg;
        pend_next            = 1'b0;
        result_valid_next    = result_valid_reg;
        cnt_next             = cnt_reg;
        mods_next            = mods_reg;
        d_next               = d_reg;
        col_next             = col_reg;
        ch_next              = ch_reg;
        zero_mode_next       = zero_mode_reg;
        q_next               = q_reg;
        base_next            = base_reg;
        pend_addr_next       = pend_addr_reg;
        pend_zero_next       = pend_zero_reg;
        result_next          = result_reg;

        if (result_valid_reg && !result_stall)
        begin
            result_valid_next = 1'b0;
        end

        if (write_enable)
        begin
            unique case (write_index)
                CFG_MODULE_COUNT:    module_count_next    = write_data[3:0];
                CFG_DISPLAY_COLUMNS: display_columns_next = write_data[6:0];
                CFG_STEP_FRAMES:     step_frames_next     = write_data[15:0];
                CFG_TEXT_LENGTH:     text_length_next     = write_data[6:0];
                default:             ;
            endcase
        end

        if (pend_reg)
        begin
            col_valid_next[col_waddr] = 1'b1;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && (item.kind == KIND_TICK))
                begin
                    mods_next  = mods_clamped;
                    cnt_next   = '0;
                    state_next = ST_BLANK;
                end
            end
            ST_BLANK:
            begin
                if (out_free)
                begin
                    result_valid_next         = 1'b1;
                    result_next.select_column = scan_column_reg;
                    result_next.shift_byte    = 8'd0;
                    result_next.latch_after   = (cnt_reg == mods_reg - 4'd1);
                    result_next.last          = 1'b0;
                    if (cnt_reg == mods_reg - 4'd1)
                    begin
                        cnt_next   = mods_reg;
                        state_next = ST_RDWAIT;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + 4'd1;
                    end
                end
            end
            ST_RDWAIT:
            begin
                state_next = ST_DATA;
            end
            ST_DATA:
            begin
                if (out_free)
                begin
                    result_valid_next         = 1'b1;
                    result_next.select_column = scan_column_reg;
                    result_next.shift_byte    = colv_rd_reg ? col_rdata : 8'd0;
                    result_next.latch_after   = (cnt_reg == 4'd1);
                    result_next.last          = (cnt_reg == 4'd1);
                    if (cnt_reg == 4'd1)
                    begin
                        state_next = ST_ADV;
                    end
                    else
                    begin
                        cnt_next   = cnt_reg - 4'd1;
                        state_next = ST_RDWAIT;
                    end
                end
            end
            ST_ADV:
            begin
                scan_column_next = scan_column_reg + 3'd1;
                state_next       = ST_IDLE;
                if (scan_column_reg == LAST_COLUMN)
                begin
                    frame_counter_next = fc_inc;
                    if (fc_inc >= step_frames_reg)
                    begin
                        frame_counter_next   = '0;
                        scroll_position_next = sp_wrap ? 9'd0 : sp_inc;
                    end
                    d_next         = '0;
                    zero_mode_next = (len == 7'd0);
                    if (cols == 7'd0)
                    begin
                        state_next = ST_IDLE;
                    end
                    else if (len == 7'd0)
                    begin
                        state_next = ST_COL;
                    end
                    else
                    begin
                        state_next = ST_SPLIT;
                    end
                end
            end
            ST_SPLIT:
            begin
                q_next     = 9'(pitch_prod[16:PITCH_SHIFT]);
                state_next = ST_DIV2_GO;
            end
            ST_DIV2_GO:
            begin
                col_next   = pitch_rem;
                state_next = ST_DIV2_WAIT;
            end
            ST_DIV2_WAIT:
            begin
                if (div_rsp.done)
                begin
                    ch_next    = div_rsp.remainder;
                    state_next = ST_TXT;
                end
            end
            ST_TXT:
            begin
                state_next = ST_BASE;
            end
            ST_BASE:
            begin
                base_next  = 10'({text_rdata, 2'b00}) + 10'(text_rdata);
                state_next = ST_COL;
            end
            ST_COL:
            begin
                pend_next      = 1'b1;
                pend_addr_next = d_reg;
                pend_zero_next = !use_font;
                if (d_reg == cols - 7'd1)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    d_next = d_reg + 7'd1;
                    if (col_reg == 3'(CHAR_PITCH - 1))
                    begin
                        col_next = '0;
                        ch_next  = (ch_inc >= len) ? 7'd0 : ch_inc;
                        if (!zero_mode_reg)
                        begin
                            state_next = ST_TXT;
                        end
                    end
                    else
                    begin
                        col_next = col_reg + 3'd1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg           <= ST_IDLE;
            module_count_reg    <= MODULE_COUNT_RST;
            display_columns_reg <= DISPLAY_COLUMNS_RST;
            step_frames_reg     <= STEP_FRAMES_RST;
            text_length_reg     <= TEXT_LENGTH_RST;
            scan_column_reg     <= '0;
            frame_counter_reg   <= '0;
            scroll_position_reg <= '0;
            col_valid_reg       <= '0;
            pend_reg            <= 1'b0;
            result_valid_reg    <= 1'b0;
            cnt_reg             <= '0;
            mods_reg            <= '0;
            d_reg               <= '0;
            col_reg             <= '0;
            ch_reg              <= '0;
            zero_mode_reg       <= 1'b0;
        end
        else
        begin
            state_reg           <= state_next;
            module_count_reg    <= module_count_next;
            display_columns_reg <= display_columns_next;
            step_frames_reg     <= step_frames_next;
            text_length_reg     <= text_length_next;
            scan_column_reg     <= scan_column_next;
            frame_counter_reg   <= frame_counter_next;
            scroll_position_reg <= scroll_position_next;
            col_valid_reg       <= col_valid_next;
            pend_reg            <= pend_next;
            result_valid_reg    <= result_valid_next;
            cnt_reg             <= cnt_next;
            mods_reg            <= mods_next;
            d_reg               <= d_next;
            col_reg             <= col_next;
            ch_reg              <= ch_next;
            zero_mode_reg       <= zero_mode_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg         <= q_next;
        base_reg      <= base_next;
        pend_addr_reg <= pend_addr_next;
        pend_zero_reg <= pend_zero_next;
        result_reg    <= result_next;
        colv_rd_reg   <= col_valid_reg[col_raddr];
    end

    assign item_stall   = (state_reg != ST_IDLE);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

`ifndef NO_ASSERTIONS
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DATA && out_free && cnt_reg == 4'd1)
        |=> (result_valid_reg && result_reg.last && result_reg.latch_after))
        else $error("final column word not marked last");

    assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (state_reg == ST_DIV2_WAIT))
        else $error("divider finished outside a wait step");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_TXT) |-> (ch_reg < len))
        else $error("character index beyond text length");

    assert property (@(posedge clk) disable iff (!rst_n)
        (scan_column_reg != $past(scan_column_reg)) |-> ($past(state_reg) == ST_ADV))
        else $error("scan column moved outside the advance step");
`endif

endmodule
